// ===== hdl/srsg_pkg.sv =====
package srsg_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned INC_W    = 8;
    localparam int unsigned FRAC_W   = 9;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // action codes carried in the input tuser
    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_STEP   = 2'd1,
        ACT_ADJUST = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // direction codes
    typedef enum logic [1:0] {
        DIR_IDLE = 2'b00,
        DIR_POS  = 2'b01,
        DIR_NEG  = 2'b11
    } t_dir;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PER   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INC  = 2'd3;

    // reset values of the configuration registers
    localparam logic [PERIOD_W-1:0] RST_START_PER = 16'd400;
    localparam logic [PERIOD_W-1:0] RST_MIN_PER   = 16'd133;
    localparam logic [INC_W-1:0]    RST_RAMP_INC  = 8'd45;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic ramp;
        logic div_wr;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_action action;
        logic    need_div;
        logic    div_done;
    } t_status;

endpackage

// ===== hdl/srsg_div.sv =====
module srsg_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [srsg_pkg::DATA_W-1:0] i_dividend,
    input  logic [srsg_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [srsg_pkg::DATA_W-1:0] o_quotient
);

    localparam int unsigned CNT_W = $clog2(srsg_pkg::DATA_W);

    logic [srsg_pkg::DATA_W-1:0] r_rem, n_rem;
    logic [srsg_pkg::DATA_W-1:0] r_quo, n_quo;
    logic [srsg_pkg::DATA_W-1:0] r_dvs;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [srsg_pkg::DATA_W:0]   rem_sh;
    logic [srsg_pkg::DATA_W+1:0] diff;
    logic                        ge;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        rem_sh = {r_rem, r_quo[srsg_pkg::DATA_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        ge     = ~diff[srsg_pkg::DATA_W+1];
        n_rem  = ge ? diff[srsg_pkg::DATA_W-1:0] : rem_sh[srsg_pkg::DATA_W-1:0];
        n_quo  = {r_quo[srsg_pkg::DATA_W-2:0], ge};
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(srsg_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/srsg_datapath.sv =====
module srsg_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  srsg_pkg::t_cmd                  i_cmd,
    output srsg_pkg::t_status               o_status,
    input  logic                            i_cfg_we,
    input  logic [srsg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srsg_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  srsg_pkg::t_action               i_action,
    input  logic [srsg_pkg::DATA_W-1:0]     i_step_count,
    input  logic [srsg_pkg::DATA_W-1:0]     i_move_time,
    output logic [srsg_pkg::DATA_W-1:0]     o_interval,
    output logic [srsg_pkg::DATA_W-1:0]     o_position,
    output logic                            o_move_over,
    output logic                            o_step_level,
    output logic                            o_dir_level,
    output logic                            o_reassert
);

    localparam int unsigned W = srsg_pkg::DATA_W;

    // configuration
    logic                          r_invert;
    logic [srsg_pkg::PERIOD_W-1:0] r_start_per;
    logic [srsg_pkg::PERIOD_W-1:0] r_min_per;
    logic [srsg_pkg::INC_W-1:0]    r_ramp_inc;

    // latched request
    srsg_pkg::t_action r_act;
    logic [W-1:0]      r_count;
    logic [W-1:0]      r_time;

    // axis state
    logic [W-1:0]                r_pos;
    srsg_pkg::t_dir              r_dir;
    logic                        r_line;
    logic [W-1:0]                r_total;
    logic [W-1:0]                r_done;
    logic [W-1:0]                r_mlt;
    logic [W-1:0]                r_period;
    logic [srsg_pkg::FRAC_W-1:0] r_frac;
    logic [W-1:0]                r_decel;
    logic                        r_reassert;

    // result register
    logic [W-1:0] r_o_interval;
    logic [W-1:0] r_o_position;
    logic         r_o_over;
    logic         r_o_line;
    logic         r_o_dir;
    logic         r_o_reassert;

    logic                        neg;
    logic [W-1:0]                mag;
    srsg_pkg::t_dir              want;
    logic                        div_start;
    logic                        div_done;
    logic [W-1:0]                quotient;
    logic [W-1:0]                dir_off;
    logic [srsg_pkg::FRAC_W-1:0] frac_sum;
    logic                        delta;
    logic [W:0]                  per_up;
    logic                        over;

    // start-request decode
    always_comb begin
        neg  = r_count[W-1];
        mag  = neg ? (W'(0) - r_count) : r_count;
        want = (neg ^ r_invert) ? srsg_pkg::DIR_NEG : srsg_pkg::DIR_POS;
    end

    assign div_start = i_cmd.exec && (r_act == srsg_pkg::ACT_START) && o_status.need_div;

    always_comb begin
        o_status.action   = r_act;
        o_status.need_div = (mag != '0) && (r_time != '0);
        o_status.div_done = div_done;
    end

    srsg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_time),
        .i_divisor  (mag),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // step offset and ramp accumulator
    always_comb begin
        case (r_dir)
            srsg_pkg::DIR_POS: dir_off = W'(1);
            srsg_pkg::DIR_NEG: dir_off = '1;
            default:           dir_off = '0;
        endcase
        frac_sum = r_frac + {1'b0, r_ramp_inc};
        delta    = frac_sum[srsg_pkg::FRAC_W-1];
        per_up   = {1'b0, r_period} + {{W{1'b0}}, delta};
        over     = (r_done >= r_total);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert    <= 1'b0;
            r_start_per <= srsg_pkg::RST_START_PER;
            r_min_per   <= srsg_pkg::RST_MIN_PER;
            r_ramp_inc  <= srsg_pkg::RST_RAMP_INC;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                srsg_pkg::CFG_INVERT:    r_invert    <= i_cfg_data[0];
                srsg_pkg::CFG_START_PER: r_start_per <= i_cfg_data;
                srsg_pkg::CFG_MIN_PER:   r_min_per   <= i_cfg_data;
                srsg_pkg::CFG_RAMP_INC:  r_ramp_inc  <= i_cfg_data[srsg_pkg::INC_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_count <= i_step_count;
            r_time  <= i_move_time;
        end
    end

    // axis state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_dir      <= srsg_pkg::DIR_IDLE;
            r_line     <= 1'b0;
            r_total    <= '0;
            r_done     <= '0;
            r_mlt      <= '0;
            r_period   <= '0;
            r_frac     <= '0;
            r_decel    <= '0;
            r_reassert <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_reassert <= 1'b0;
            end
            if (i_cmd.exec) begin
                case (r_act)
                    srsg_pkg::ACT_START: begin
                        r_done  <= '0;
                        r_total <= mag;
                        r_mlt   <= r_time;
                        if (mag != '0) begin
                            if (r_dir != want) begin
                                r_dir      <= want;
                                r_reassert <= r_line;
                            end
                            if (r_time == '0) begin
                                r_frac   <= '0;
                                r_period <= W'(r_start_per);
                                r_decel  <= mag;
                            end
                        end else begin
                            r_period <= '0;
                            r_decel  <= '0;
                        end
                    end
                    srsg_pkg::ACT_STEP: begin
                        r_pos  <= r_pos + dir_off;
                        r_line <= ~r_line;
                        if (r_done != '1) begin
                            r_done <= r_done + W'(1);
                        end
                    end
                    srsg_pkg::ACT_ADJUST: begin
                        r_pos <= r_pos + r_count;
                    end
                    default: ;
                endcase
            end
            // constant-rate period from the divider
            if (i_cmd.div_wr) begin
                r_period <= quotient;
            end
            // ramp update after a step
            if (i_cmd.ramp && !over && (r_mlt == '0)) begin
                if (r_done > r_decel) begin
                    r_frac   <= {1'b0, frac_sum[srsg_pkg::FRAC_W-2:0]};
                    r_period <= per_up[W] ? '1 : per_up[W-1:0];
                end else if (r_period > W'(r_min_per)) begin
                    r_frac   <= {1'b0, frac_sum[srsg_pkg::FRAC_W-2:0]};
                    r_period <= r_period - {{(W-1){1'b0}}, delta};
                    r_decel  <= r_total - r_done;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_interval <= over ? '0 : r_period;
            r_o_position <= r_pos;
            r_o_over     <= over;
            r_o_line     <= r_line;
            r_o_dir      <= (r_dir == srsg_pkg::DIR_POS);
            r_o_reassert <= r_reassert;
        end
    end

    assign o_interval   = r_o_interval;
    assign o_position   = r_o_position;
    assign o_move_over  = r_o_over;
    assign o_step_level = r_o_line;
    assign o_dir_level  = r_o_dir;
    assign o_reassert   = r_o_reassert;

endmodule

// ===== hdl/srsg_ctrl.sv =====
module srsg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  srsg_pkg::t_status i_status,
    output srsg_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_RAMP,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    // command decode
    always_comb begin
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.ramp     = (r_state == S_RAMP);
        o_cmd.div_wr   = (r_state == S_DIV) && i_status.div_done;
        o_cmd.out_load = (r_state == S_FINISH) && slot_free;
    end

    // sequencer and result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (i_status.action)
                        srsg_pkg::ACT_START:
                            r_state <= i_status.need_div ? S_DIV : S_FINISH;
                        srsg_pkg::ACT_STEP:
                            r_state <= S_RAMP;
                        default:
                            r_state <= S_FINISH;
                    endcase
                end
                S_DIV: begin
                    if (i_status.div_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_RAMP: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/stepper_ramp_step_generator.sv =====
// One stepper axis. Each request (start move, step due, adjust position) yields exactly
// one result. Adjust requests and ramped starts pass the execute and finish states,
// step-due requests also the ramp state, constant-rate starts also the divide state of
// the bit-serial 32-bit divider forming move_time / |steps| one quotient bit per cycle.
// Requests are handled one at a time; a new request is accepted while the previous
// result still waits in the output register. Configuration writes are always accepted.
module stepper_ramp_step_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // step_count[31:0], move_time[63:32]
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // interval[31:0], position[63:32]
    output logic [3:0]  m_axis_tuser,  // move_over[0], step_level[1], dir_level[2],
                                       // reassert_step[3]
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    srsg_pkg::t_cmd    cmd;
    srsg_pkg::t_status status;

    logic [31:0] interval;
    logic [31:0] position;
    logic        move_over;
    logic        step_level;
    logic        dir_level;
    logic        reassert;

    assign cfg_ready = 1'b1;

    srsg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    srsg_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (cfg_valid),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_action     (srsg_pkg::t_action'(s_axis_tuser)),
        .i_step_count (s_axis_tdata[31:0]),
        .i_move_time  (s_axis_tdata[63:32]),
        .o_interval   (interval),
        .o_position   (position),
        .o_move_over  (move_over),
        .o_step_level (step_level),
        .o_dir_level  (dir_level),
        .o_reassert   (reassert)
    );

    // result packing
    assign m_axis_tdata = {position, interval};
    assign m_axis_tuser = {reassert, dir_level, step_level, move_over};

endmodule

// ===== hdl/srsg_checker.sv =====
module srsg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [15:0] cfg_data
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // finished move reports a zero interval
    a_over_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("interval nonzero on finished move");

    // re-pulse only asked for while the step line is high
    a_reassert_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[1])
        else $error("re-pulse with step line low");

endmodule

bind stepper_ramp_step_generator srsg_checker u_srsg_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// one result as seen on the master side
typedef struct packed {
    logic [31:0] interval;
    logic        move_over;
    logic        step_level;
    logic        dir_level;
    logic        reassert;
    logic [31:0] position;
} t_axis_status;

class t_ramp_axis_scoreboard;
    // configuration copy
    bit          invert;
    bit [15:0]   start_per;
    bit [15:0]   min_per;
    bit [7:0]    ramp_inc;
    // axis state copy
    bit [31:0]   pos;
    srsg_pkg::t_dir dir;
    bit          step_ln;
    bit [31:0]   steps_total;
    bit [31:0]   steps_done;
    bit [31:0]   move_len;
    bit [31:0]   period;
    bit [8:0]    ramp_acc;
    bit [31:0]   decel_point;
    // statuses still to come out of the block
    t_axis_status axis_status_q[$];
    int errors, checked;
    int n_ramped, n_linear, n_steps, n_adjust;

    function new();
        invert      = 1'b0;
        start_per   = srsg_pkg::RST_START_PER;
        min_per     = srsg_pkg::RST_MIN_PER;
        ramp_inc    = srsg_pkg::RST_RAMP_INC;
        pos         = '0;
        dir         = srsg_pkg::DIR_IDLE;
        step_ln     = 1'b0;
        steps_total = '0;
        steps_done  = '0;
        move_len    = '0;
        period      = '0;
        ramp_acc    = '0;
        decel_point = '0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] val);
        case (idx)
            srsg_pkg::CFG_INVERT:    invert    = val[0];
            srsg_pkg::CFG_START_PER: start_per = val;
            srsg_pkg::CFG_MIN_PER:   min_per   = val;
            srsg_pkg::CFG_RAMP_INC:  ramp_inc  = val[7:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return axis_status_q.size();
    endfunction

    // fractional accumulator: the carry into bit 8 is the period change
    function bit [31:0] ramp_carry();
        bit [31:0] d;
        ramp_acc = ramp_acc + {1'b0, ramp_inc};
        d = {31'd0, ramp_acc[8]};
        ramp_acc[8] = 1'b0;
        return d;
    endfunction

    function void note_request(srsg_pkg::t_action act, logic [31:0] count,
                               logic [31:0] mtime);
        bit        neg;
        bit [31:0] mag;
        bit [31:0] d;
        srsg_pkg::t_dir want;
        t_axis_status r;
        r = '0;
        case (act)
            srsg_pkg::ACT_START: begin
                neg  = count[31];
                mag  = neg ? (32'd0 - count) : count;
                want = (neg != invert) ? srsg_pkg::DIR_NEG : srsg_pkg::DIR_POS;
                steps_done  = '0;
                steps_total = mag;
                move_len    = mtime;
                if (mag != 0) begin
                    // direction flip with the line high needs a re-pulse
                    if (dir != want) begin
                        dir        = want;
                        r.reassert = step_ln;
                    end
                    if (mtime != 0) begin
                        period = mtime / mag;
                        n_linear++;
                    end else begin
                        ramp_acc    = '0;
                        period      = {16'd0, start_per};
                        decel_point = mag;
                        n_ramped++;
                    end
                    r.move_over = 1'b0;
                    r.interval  = period;
                end else begin
                    period      = '0;
                    decel_point = '0;
                    r.move_over = 1'b1;
                    r.interval  = '0;
                end
            end
            srsg_pkg::ACT_STEP: begin
                n_steps++;
                if (dir == srsg_pkg::DIR_POS) pos = pos + 32'd1;
                else if (dir == srsg_pkg::DIR_NEG) pos = pos - 32'd1;
                step_ln = ~step_ln;
                if (steps_done != 32'hFFFF_FFFF) steps_done++;
                if (steps_done >= steps_total) begin
                    r.move_over = 1'b1;
                    r.interval  = '0;
                end else begin
                    // ramped move: decelerate past the mirror point, else accelerate
                    if (move_len == 0) begin
                        if (steps_done > decel_point) begin
                            d = ramp_carry();
                            if (period > 32'hFFFF_FFFF - d) period = 32'hFFFF_FFFF;
                            else period = period + d;
                        end else if (period > {16'd0, min_per}) begin
                            period      = period - ramp_carry();
                            decel_point = steps_total - steps_done;
                        end
                    end
                    r.move_over = 1'b0;
                    r.interval  = period;
                end
            end
            default: begin
                if (act == srsg_pkg::ACT_ADJUST) begin
                    pos = pos + count;
                    n_adjust++;
                end
                r.move_over = (steps_done >= steps_total);
                r.interval  = r.move_over ? 32'd0 : period;
            end
        endcase
        r.step_level = step_ln;
        r.dir_level  = (dir == srsg_pkg::DIR_POS);
        r.position   = pos;
        axis_status_q.push_back(r);
    endfunction

    function void compare_field(string field, bit [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    function void check_result(logic [63:0] tdata, logic [3:0] tuser);
        t_axis_status e;
        if (axis_status_q.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, expected nothing, actual %0h/%0h",
                     $time, tdata, tuser);
            return;
        end
        e = axis_status_q.pop_front();
        checked++;
        compare_field("interval",      e.interval,              tdata[31:0]);
        compare_field("position",      e.position,              tdata[63:32]);
        compare_field("move_over",     {31'd0, e.move_over},    {31'd0, tuser[0]});
        compare_field("step_level",    {31'd0, e.step_level},   {31'd0, tuser[1]});
        compare_field("dir_level",     {31'd0, e.dir_level},    {31'd0, tuser[2]});
        compare_field("reassert_step", {31'd0, e.reassert},     {31'd0, tuser[3]});
    endfunction
endclass

module tb_top;

    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 950;
    localparam int PHASES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // step_count[31:0], move_time[63:32]
    logic [1:0]  s_axis_tuser = '0;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // interval[31:0], position[63:32]
    logic [3:0]  m_axis_tuser;        // move_over, step_level, dir_level, reassert_step
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    t_ramp_axis_scoreboard sb = new();
    bit no_idle = 1'b0;
    int items_sent = 0;
    int n_settings = 0;
    int rx_wait = 0;
    int rx_draw;
    int quiet_cycles = 0;

    stepper_ramp_step_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    // result side stalls a random number of cycles after each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_draw = draw_wait();
            rx_wait       <= rx_draw;
            m_axis_tready <= (rx_draw == 0);
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            rx_wait       <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    // handshake monitor feeding the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(srsg_pkg::t_action'(s_axis_tuser), s_axis_tdata[31:0],
                                s_axis_tdata[63:32]);
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d quiet cycles at %0t", quiet_cycles, $time);
                $display("FAIL stepper_ramp_step_generator");
                $finish;
            end
        end
    end

    task automatic send_request(srsg_pkg::t_action act, logic [31:0] count,
                                logic [31:0] mtime);
        int gap;
        gap = draw_wait();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {mtime, count};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (act != srsg_pkg::ACT_NONE) items_sent++;
    endtask

    // hold the sender until every result is back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(bit inv, logic [15:0] sp, logic [15:0] mp, logic [7:0] inc);
        cfg_write(srsg_pkg::CFG_INVERT, {15'd0, inv});
        cfg_write(srsg_pkg::CFG_START_PER, sp);
        cfg_write(srsg_pkg::CFG_MIN_PER, mp);
        cfg_write(srsg_pkg::CFG_RAMP_INC, {8'd0, inc});
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // start a move and step it, sometimes cut short or run past its end, with random adjusts
    task automatic run_move();
        int n, k, pick;
        bit neg;
        logic [31:0] mtime;
        n   = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 40);
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: mtime = $urandom();
            1: mtime = $urandom_range(1, n);
            default: mtime = '0;
        endcase
        send_request(srsg_pkg::ACT_START, neg ? -n : n, mtime);
        pick = $urandom_range(0, 9);
        if (pick == 0) k = $urandom_range(0, n - 1);
        else if (pick == 1) k = n + $urandom_range(1, 3);
        else k = n;
        for (int i = 0; i < k; i++) begin
            send_request(srsg_pkg::ACT_STEP, $urandom(), $urandom());
            if ($urandom_range(0, 15) == 0)
                send_request(srsg_pkg::ACT_ADJUST, $urandom_range(0, 20) - 10, $urandom());
        end
    endtask

    initial begin
        int phase_end, base;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle step, adjust, unused action, both move kinds, edge values
        send_request(srsg_pkg::ACT_STEP, '0, '0);
        send_request(srsg_pkg::ACT_ADJUST, 32'd5, '0);
        send_request(srsg_pkg::ACT_NONE, '1, '1);
        send_request(srsg_pkg::ACT_START, 32'd6, '0);
        repeat (7) send_request(srsg_pkg::ACT_STEP, '0, '0);
        send_request(srsg_pkg::ACT_START, -32'sd3, 32'd2);
        repeat (3) send_request(srsg_pkg::ACT_STEP, '0, '0);
        send_request(srsg_pkg::ACT_START, '0, 32'd123);
        send_request(srsg_pkg::ACT_START, 32'h8000_0000, '1);
        send_request(srsg_pkg::ACT_STEP, '0, '0);
        send_request(srsg_pkg::ACT_START, 32'h7FFF_FFFF, '1);
        send_request(srsg_pkg::ACT_ADJUST, 32'h7FFF_FFFF, '0);
        send_request(srsg_pkg::ACT_ADJUST, 32'h7FFF_FFFF, '0);
        send_request(srsg_pkg::ACT_ADJUST, 32'h8000_0000, '0);

        // random phases, each under its own register setting
        base = items_sent;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: configure(1'b1, 16'hFFFF, 16'd1, 8'hFF);
                1: configure(1'b0, 16'd1, 16'hFFFF, 8'd0);
                2: configure(1'($urandom_range(0, 1)), 16'd140, 16'd133, 8'hFF);
                3: configure(1'b0, srsg_pkg::RST_START_PER, srsg_pkg::RST_MIN_PER,
                             srsg_pkg::RST_RAMP_INC);
                default: begin
                    int sp;
                    sp = $urandom_range(1, 2000);
                    configure(1'($urandom_range(0, 1)), 16'(sp), 16'($urandom_range(1, sp)),
                              8'($urandom_range(0, 255)));
                end
            endcase
            no_idle   = (ph % 3 == 2);
            phase_end = base + (ph + 1) * RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: run_move();
                    6: send_request(srsg_pkg::t_action'($urandom_range(0, 3)), $urandom(),
                                    $urandom());
                    7: send_request(srsg_pkg::ACT_ADJUST, $urandom(), $urandom());
                    8: send_request(srsg_pkg::ACT_START, '0, $urandom());
                    default: send_request($urandom_range(0, 1) ? srsg_pkg::ACT_STEP
                                                               : srsg_pkg::ACT_NONE,
                                          $urandom(), $urandom());
                endcase
            end
        end
        no_idle = 1'b0;
        wait_idle();

        $display("run covered %0d requests: %0d ramped and %0d constant-rate moves, %0d steps,",
                 items_sent, sb.n_ramped, sb.n_linear, sb.n_steps);
        $display("%0d adjusts, %0d results checked, %0d register settings, %0d mismatches",
                 sb.n_adjust, sb.checked, n_settings, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS stepper_ramp_step_generator");
        end else begin
            $display("FAIL stepper_ramp_step_generator");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/srsg_pkg.sv
hdl/srsg_div.sv
hdl/srsg_datapath.sv
hdl/srsg_ctrl.sv
hdl/stepper_ramp_step_generator.sv
hdl/srsg_checker.sv
bench/tb_top.sv
